// ===== design/irm_pkg.sv =====
// package for interval_range_map: payload structs, constants, command/status types
// used by irm_ctrl, irm_dp and interval_range_map_top
`default_nettype none
package irm_pkg;
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF    = 32;
  localparam int VALUE_BITS_DEF  = 8;
  localparam logic [7:0] DEFAULT_RESET = 8'd65;

  localparam logic REQ_ASSIGN = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                      req_type;
    logic [KEY_BITS_DEF-1:0]   range_begin;
    logic [KEY_BITS_DEF-1:0]   range_end;
    logic [VALUE_BITS_DEF-1:0] new_value;
    logic [KEY_BITS_DEF-1:0]   lookup_key;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_BITS_DEF-1:0] read_value;
    logic [1:0]                status;
    logic [4:0]                entry_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, reset scan
    logic scan;      // one step of the scan pass (a table entry or a push)
    logic commit;    // start the copy pass (reset copy index)
    logic copy;      // one entry of the copy pass
    logic finish;    // build result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic copy_last;
    logic empty_req;
    logic is_lookup;
    logic overflow;
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== design/interval_range_map_top.sv =====
// interval_range_map top level: sorted boundary table mapping signed keys to values
// depends on irm_pkg, irm_ctrl, irm_dp
//
// usage: in_valid/in_ready take one request item (assign a range or look up a key),
// out_valid/out_ready return one result item per request. cfg_we with cfg_wdata
// writes the default value; the user must write it only while the block is idle,
// and the block itself does not enforce this. each request walks the table: a pass
// over the entries pushing those below begin, then the begin push, the end push
// and a sweep of the entries above end; the lookup value is tracked in this pass.
// a successful assign then copies the rebuilt entries into the table.
// a lookup or refused assign skips the copy; an empty interval skips scan and copy.
// one request is in flight at a time; the next item can be taken once the
// controller is back in idle and the output register is free or being drained.
// a stalled receiver simply holds out_valid and the result.
// reset empties the table (entry count zero) and sets the default to 65.
`default_nettype none
module interval_range_map_top #(
  parameter int TABLE_DEPTH = irm_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire irm_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output irm_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata
);
  localparam int VALUE_BITS = irm_pkg::VALUE_BITS_DEF;

  logic [VALUE_BITS-1:0] dflt_r;
  irm_pkg::dp_cmd_t  cmd;
  irm_pkg::dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n)      dflt_r <= VALUE_BITS'(irm_pkg::DEFAULT_RESET);
    else if (cfg_we) dflt_r <= VALUE_BITS'(cfg_wdata);
  end

  irm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  irm_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk, .rst_n, .default_value(dflt_r), .in_item(in_data), .cmd, .stat,
    .out_item(out_data)
  );
endmodule
`default_nettype wire

// ===== design/irm_ctrl.sv =====
// controller for interval_range_map: sequences load, scan, copy and result
// depends on irm_pkg
`default_nettype none
module irm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire irm_pkg::dp_stat_t stat,
  output irm_pkg::dp_cmd_t      cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_COPY = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;

  assign out_valid = ov_r;
  assign in_ready  = (state_r == S_IDLE) && (!ov_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.empty_req) begin
          state_nxt = S_FIN;
        end else begin
          cmd.scan = 1'b1;
          if (stat.scan_last) state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.is_lookup || stat.overflow) begin
          state_nxt = S_FIN;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_COPY;
        end
      end
      S_COPY: begin
        if (stat.copy_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.copy = 1'b1;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        ov_nxt     = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== design/irm_dp.sv =====
// datapath for interval_range_map: boundary table, scratch table, scan logic
// depends on irm_pkg
`default_nettype none
module irm_dp #(
  parameter int TABLE_DEPTH = irm_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [irm_pkg::VALUE_BITS_DEF-1:0] default_value,
  input  wire irm_pkg::in_item_t     in_item,
  input  wire irm_pkg::dp_cmd_t      cmd,
  output irm_pkg::dp_stat_t          stat,
  output irm_pkg::out_item_t         out_item
);
  localparam int KEY_BITS   = irm_pkg::KEY_BITS_DEF;
  localparam int VALUE_BITS = irm_pkg::VALUE_BITS_DEF;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SD = TABLE_DEPTH + 2;
  localparam int SW = $clog2(SD + 1);
  // scan steps: table entries, then begin push, end push
  localparam int PW = $clog2(TABLE_DEPTH + 3);

  logic [KEY_BITS-1:0]   keys_r [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] vals_r [TABLE_DEPTH];
  logic [KEY_BITS-1:0]   skeys_r [SD];
  logic [VALUE_BITS-1:0] svals_r [SD];
  logic [CW-1:0]         used_r;

  logic                  typ_r;
  logic [KEY_BITS-1:0]   beg_r, end_r, lk_r;
  logic [VALUE_BITS-1:0] nv_r;
  logic [PW-1:0]         pos_r;
  logic                  phase_r;       // 0 up to the begin push, 1 from the end push on
  logic [SW-1:0]         scnt_r;
  logic [VALUE_BITS-1:0] slast_r;
  logic [VALUE_BITS-1:0] endv_r, lkv_r;
  logic [SW-1:0]         cpy_r;
  logic [1:0]            st_r;

  logic [KEY_BITS-1:0]   ek;
  logic [VALUE_BITS-1:0] ev;
  logic                  in_tab;
  logic                  end_slot;
  logic                  push_req;
  logic [KEY_BITS-1:0]   push_k;
  logic [VALUE_BITS-1:0] push_v;

  function automatic logic slt(input logic [KEY_BITS-1:0] a, input logic [KEY_BITS-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  assign in_tab   = (CW'(pos_r) < used_r) && (int'(pos_r) < TABLE_DEPTH);
  assign end_slot = phase_r && (pos_r == PW'(TABLE_DEPTH + 1));
  assign ek       = keys_r[pos_r[IW-1:0]];
  assign ev       = vals_r[pos_r[IW-1:0]];

  always_comb begin
    push_req = 1'b0;
    push_k   = ek;
    push_v   = ev;
    if (in_tab) begin
      if (!phase_r) push_req = slt(ek, beg_r);
      else          push_req = slt(end_r, ek);
    end else if (!phase_r) begin
      push_req = 1'b1;
      push_k   = beg_r;
      push_v   = nv_r;
    end else if (end_slot) begin
      push_req = 1'b1;
      push_k   = end_r;
      push_v   = endv_r;
    end
  end

  assign stat.empty_req = (typ_r == irm_pkg::REQ_ASSIGN) && !slt(beg_r, end_r);
  assign stat.is_lookup = (typ_r == irm_pkg::REQ_LOOKUP);
  assign stat.overflow  = scnt_r > SW'(TABLE_DEPTH);
  assign stat.scan_last = phase_r && !in_tab && !end_slot;
  assign stat.copy_last = cpy_r >= scnt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      typ_r   <= in_item.req_type;
      beg_r   <= KEY_BITS'(in_item.range_begin);
      end_r   <= KEY_BITS'(in_item.range_end);
      nv_r    <= VALUE_BITS'(in_item.new_value);
      lk_r    <= KEY_BITS'(in_item.lookup_key);
      pos_r   <= '0;
      phase_r <= 1'b0;
      scnt_r  <= '0;
      slast_r <= default_value;
      endv_r  <= default_value;
      lkv_r   <= default_value;
    end
    if (cmd.scan) begin
      if (in_tab) begin
        // running values at end key and lookup key
        if (!slt(end_r, ek)) endv_r <= ev;
        if (!slt(lk_r, ek))  lkv_r  <= ev;
      end
      if (push_req && push_v != slast_r) begin
        if (scnt_r < SW'(SD)) begin
          skeys_r[scnt_r[$clog2(SD)-1:0]] <= push_k;
          svals_r[scnt_r[$clog2(SD)-1:0]] <= push_v;
          scnt_r <= scnt_r + 1'b1;
        end
        slast_r <= push_v;
      end
      if (in_tab) begin
        pos_r <= pos_r + 1'b1;
      end else if (!phase_r) begin
        // begin pushed; end push and upper sweep follow
        phase_r <= 1'b1;
        pos_r   <= PW'(TABLE_DEPTH + 1);
      end
    end
    if (end_slot && cmd.scan) begin
      pos_r <= '0;
    end
    if (cmd.commit) cpy_r <= '0;
    if (cmd.copy) begin
      keys_r[cpy_r[IW-1:0]] <= skeys_r[cpy_r[$clog2(SD)-1:0]];
      vals_r[cpy_r[IW-1:0]] <= svals_r[cpy_r[$clog2(SD)-1:0]];
      cpy_r <= cpy_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      st_r   <= irm_pkg::ST_DONE;
    end else if (cmd.finish) begin
      if (typ_r == irm_pkg::REQ_LOOKUP) begin
        st_r <= irm_pkg::ST_DONE;
      end else if (!slt(beg_r, end_r)) begin
        st_r <= irm_pkg::ST_EMPTY;
      end else if (scnt_r > SW'(TABLE_DEPTH)) begin
        st_r <= irm_pkg::ST_FULL;
      end else begin
        st_r   <= irm_pkg::ST_DONE;
        used_r <= CW'(scnt_r);
      end
    end
  end

  logic [VALUE_BITS-1:0] rv_r;
  always_ff @(posedge clk) begin
    if (cmd.finish) rv_r <= (typ_r == irm_pkg::REQ_LOOKUP) ? lkv_r : '0;
  end

  assign out_item.read_value  = rv_r;
  assign out_item.status      = st_r;
  assign out_item.entry_count = 5'(used_r);
endmodule
`default_nettype wire
